[rtl/wavp_pkg.sv]
// ============================================================================
// wavp_pkg
// Shared constants, tag lookup and controller/datapath interface types for
// the WAV header and sample parser.
// ============================================================================
package wavp_pkg;

  localparam logic [5:0] HDR_LEN  = 6'd44;
  localparam logic [5:0] HDR_LAST = 6'd43;

  // header status codes
  localparam logic [3:0] STAT_OK       = 4'd0;
  localparam logic [3:0] STAT_RIFF     = 4'd1;
  localparam logic [3:0] STAT_WAVE     = 4'd2;
  localparam logic [3:0] STAT_FMT      = 4'd3;
  localparam logic [3:0] STAT_FMT_SIZE = 4'd4;
  localparam logic [3:0] STAT_NOT_PCM  = 4'd5;
  localparam logic [3:0] STAT_DATA     = 4'd6;
  localparam logic [3:0] STAT_RATE     = 4'd7;
  localparam logic [3:0] STAT_ALIGN    = 4'd8;
  localparam logic [3:0] STAT_CHAN     = 4'd9;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  localparam logic [31:0] FMT_SIZE_PCM = 32'd16;
  localparam logic [15:0] FORMAT_PCM   = 16'd1;
  localparam logic [15:0] MAX_CHAN     = 16'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic mul1;
    logic mul2;
    logic chk;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic hdr_last;
    logic smp_done;
  } dp_stat_t;

  // "RIFF", "WAVE", "fmt ", "data"
  function automatic logic [7:0] tag_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h52;
      4'd1:    c = 8'h49;
      4'd2:    c = 8'h46;
      4'd3:    c = 8'h46;
      4'd4:    c = 8'h57;
      4'd5:    c = 8'h41;
      4'd6:    c = 8'h56;
      4'd7:    c = 8'h45;
      4'd8:    c = 8'h66;
      4'd9:    c = 8'h6D;
      4'd10:   c = 8'h74;
      4'd11:   c = 8'h20;
      4'd12:   c = 8'h64;
      4'd13:   c = 8'h61;
      4'd14:   c = 8'h74;
      4'd15:   c = 8'h61;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[rtl/wavp_ctrl.sv]
// ============================================================================
// wavp_ctrl
// Sequencer: byte intake, header check multiply steps and result beat.
// ============================================================================
module wavp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  wavp_pkg::dp_stat_t dp_stat,
  output wavp_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IN,
    S_MUL1,
    S_MUL2,
    S_CHK,
    S_OUT
  } state_t;

  state_t state;
  logic   accept;

  assign accept    = in_valid && (state == S_IN);
  assign in_stall  = (state != S_IN);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd.accept = accept;
    cmd.mul1   = (state == S_MUL1);
    cmd.mul2   = (state == S_MUL2);
    cmd.chk    = (state == S_CHK);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IN;
    end else begin
      case (state)
        S_IN: begin
          if (accept && dp_stat.hdr_last) begin
            state <= S_MUL1;
          end else if (accept && dp_stat.smp_done) begin
            state <= S_OUT;
          end
        end
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_CHK;
        S_CHK:  state <= S_OUT;
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IN;
          end
        end
        default: state <= S_IN;
      endcase
    end
  end

endmodule

[rtl/wavp_datapath.sv]
// ============================================================================
// wavp_datapath
// Header byte capture, tag compare, check multipliers, sample assembly and
// the result register.
// ============================================================================
module wavp_datapath (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         byte_in,
  input  logic               start_req,
  input  wavp_pkg::cmd_t     cmd,
  output wavp_pkg::dp_stat_t dp_stat,
  output logic               kind,
  output logic [3:0]         status,
  output logic [15:0]        num_chan,
  output logic [31:0]        rate_hz,
  output logic [15:0]        sample_bits,
  output logic [31:0]        data_len,
  output logic [15:0]        chan_index,
  output logic signed [31:0] pcm_value,
  output logic               last
);

  // header state
  logic [5:0]        pos;
  logic [3:0]        tag_flags;
  logic [19:0][7:0]  fmt_bytes;
  logic [3:0][7:0]   size_bytes;

  // check products
  logic [31:0] prod_cb;
  logic [63:0] prod_all;
  logic [18:0] frame_len;

  // data phase state
  logic        frame_ok;
  logic [31:0] rem;
  logic [31:0] acc;
  logic [1:0]  bis;
  logic [15:0] chan_cnt;

  // decoded header fields
  logic [31:0] fmt_size;
  logic [15:0] format;
  logic [31:0] bytes_per_sec;
  logic [15:0] align;
  logic [12:0] nb;

  // per-byte combinational
  logic [5:0]  pos_eff;
  logic [3:0]  tag_eff;
  logic [3:0]  tag_next;
  logic        in_hdr;
  logic [5:0]  off;
  logic [3:0]  tag_idx;
  logic [1:0]  tag_sel;
  logic        is_tag;
  logic        frame_start;
  logic        use_byte;
  logic        smp_end;
  logic [31:0] rem_dec;
  logic [31:0] acc_mrg;
  logic [31:0] sext;
  logic [16:0] chan_inc;
  logic [3:0]  stat_calc;

  assign fmt_size      = {fmt_bytes[3], fmt_bytes[2], fmt_bytes[1], fmt_bytes[0]};
  assign format        = {fmt_bytes[5], fmt_bytes[4]};
  assign num_chan      = {fmt_bytes[7], fmt_bytes[6]};
  assign rate_hz       = {fmt_bytes[11], fmt_bytes[10], fmt_bytes[9], fmt_bytes[8]};
  assign bytes_per_sec = {fmt_bytes[15], fmt_bytes[14], fmt_bytes[13], fmt_bytes[12]};
  assign align         = {fmt_bytes[17], fmt_bytes[16]};
  assign sample_bits   = {fmt_bytes[19], fmt_bytes[18]};
  assign data_len      = {size_bytes[3], size_bytes[2], size_bytes[1], size_bytes[0]};
  assign nb            = sample_bits[15:3];

  // a start byte is taken as byte 0 of a fresh header
  assign pos_eff = start_req ? 6'd0 : pos;
  assign tag_eff = start_req ? 4'hF : tag_flags;
  assign in_hdr  = (pos_eff < wavp_pkg::HDR_LEN);
  assign off     = pos_eff - 6'd16;

  always_comb begin
    is_tag  = 1'b0;
    tag_idx = 4'd0;
    tag_sel = 2'd0;
    if (pos_eff < 6'd4) begin
      is_tag  = 1'b1;
      tag_idx = pos_eff[3:0];
      tag_sel = 2'd0;
    end else if (pos_eff >= 6'd8 && pos_eff < 6'd12) begin
      is_tag  = 1'b1;
      tag_idx = 4'(pos_eff - 6'd4);
      tag_sel = 2'd1;
    end else if (pos_eff >= 6'd12 && pos_eff < 6'd16) begin
      is_tag  = 1'b1;
      tag_idx = 4'(pos_eff - 6'd4);
      tag_sel = 2'd2;
    end else if (pos_eff >= 6'd36 && pos_eff < 6'd40) begin
      is_tag  = 1'b1;
      tag_idx = 4'(pos_eff - 6'd24);
      tag_sel = 2'd3;
    end
    tag_next = tag_eff;
    if (is_tag && (byte_in != wavp_pkg::tag_char(tag_idx))) begin
      tag_next[tag_sel] = 1'b0;
    end
  end

  // sample assembly
  assign frame_start = (bis == 2'd0) && (chan_cnt == 16'd0);
  assign use_byte    = !in_hdr && frame_ok && (!frame_start || (rem >= 32'(frame_len)));
  assign smp_end     = (({1'b0, bis} + 3'd1) == nb[2:0]);
  assign rem_dec     = rem - 32'd1;
  assign chan_inc    = {1'b0, chan_cnt} + 17'd1;

  always_comb begin
    acc_mrg = acc;
    acc_mrg[{bis, 3'b000} +: 8] = byte_in;
  end

  always_comb begin
    case (nb[2:0])
      3'd1:    sext = {{24{acc_mrg[7]}}, acc_mrg[7:0]};
      3'd2:    sext = {{16{acc_mrg[15]}}, acc_mrg[15:0]};
      3'd3:    sext = {{8{acc_mrg[23]}}, acc_mrg[23:0]};
      default: sext = acc_mrg;
    endcase
  end

  assign dp_stat.hdr_last = in_hdr && (pos_eff == wavp_pkg::HDR_LAST);
  assign dp_stat.smp_done = use_byte && smp_end;

  // later checks override earlier ones
  always_comb begin
    stat_calc = wavp_pkg::STAT_OK;
    if (!tag_flags[0]) stat_calc = wavp_pkg::STAT_RIFF;
    if (!tag_flags[1]) stat_calc = wavp_pkg::STAT_WAVE;
    if (!tag_flags[2]) stat_calc = wavp_pkg::STAT_FMT;
    if (fmt_size != wavp_pkg::FMT_SIZE_PCM) stat_calc = wavp_pkg::STAT_FMT_SIZE;
    if (format != wavp_pkg::FORMAT_PCM) stat_calc = wavp_pkg::STAT_NOT_PCM;
    if (!tag_flags[3]) stat_calc = wavp_pkg::STAT_DATA;
    if (prod_all[63:3] != {29'd0, bytes_per_sec}) stat_calc = wavp_pkg::STAT_RATE;
    if (prod_cb[31:3] != {13'd0, align}) stat_calc = wavp_pkg::STAT_ALIGN;
    if (num_chan > wavp_pkg::MAX_CHAN) stat_calc = wavp_pkg::STAT_CHAN;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= 6'd0;
      tag_flags <= 4'hF;
      frame_ok  <= 1'b0;
      rem       <= 32'd0;
      bis       <= 2'd0;
      chan_cnt  <= 16'd0;
    end else if (cmd.accept) begin
      if (in_hdr) begin
        pos       <= pos_eff + 6'd1;
        tag_flags <= tag_next;
        if (dp_stat.hdr_last) begin
          frame_ok <= (nb >= 13'd1) && (nb <= 13'd4) && (num_chan != 16'd0);
          rem      <= {byte_in, size_bytes[2], size_bytes[1], size_bytes[0]};
          bis      <= 2'd0;
          chan_cnt <= 16'd0;
        end
      end else if (use_byte) begin
        rem <= rem_dec;
        if (smp_end) begin
          bis      <= 2'd0;
          chan_cnt <= (chan_inc >= {1'b0, num_chan}) ? 16'd0 : chan_inc[15:0];
        end else begin
          bis <= bis + 2'd1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept && in_hdr) begin
      if (pos_eff >= 6'd16 && pos_eff < 6'd36) begin
        fmt_bytes[off[4:0]] <= byte_in;
      end
      if (pos_eff >= 6'd40) begin
        size_bytes[pos_eff[1:0]] <= byte_in;
      end
    end
    if (cmd.accept && use_byte) begin
      acc <= acc_mrg;
    end
    if (cmd.mul1) begin
      prod_cb   <= 32'(num_chan) * 32'(sample_bits);
      frame_len <= 19'(nb[2:0]) * 19'(num_chan);
    end
    if (cmd.mul2) begin
      prod_all <= 64'(prod_cb) * 64'(rate_hz);
    end
    if (cmd.chk) begin
      kind       <= wavp_pkg::KIND_STATUS;
      status     <= stat_calc;
      chan_index <= 16'd0;
      pcm_value  <= 32'sd0;
      last       <= 1'b0;
    end else if (cmd.accept && dp_stat.smp_done) begin
      kind       <= wavp_pkg::KIND_SAMPLE;
      status     <= wavp_pkg::STAT_OK;
      chan_index <= chan_cnt;
      pcm_value  <= signed'(sext);
      // flag only the closing sample of the final whole frame
      last       <= (chan_inc >= {1'b0, num_chan}) && (rem_dec < 32'(frame_len));
    end
  end

endmodule

[rtl/wav_pcm_header_and_sample_parser.sv]
// ============================================================================
// wav_pcm_header_and_sample_parser
// Byte-wide WAV (RIFF/PCM) header check and interleaved sample decoder.
// ============================================================================
// Bytes arrive one per beat. The first 44 bytes form the canonical header; the
// 44th byte is followed by the S_MUL1, S_MUL2 and S_CHK states, in which the
// channel*bits and channel*rate*bits products are formed through two registered
// multiplier steps (16x16, then 32x32) and the nine checks are resolved, after
// which a single status beat is offered. A data byte that completes a sample
// holds the input until its sample beat is taken. Only whole frames within the
// data chunk size are decoded; a remaining-byte counter is checked against the
// frame size at every frame start. start_req on any byte restarts header
// parsing at that byte.
module wav_pcm_header_and_sample_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         byte_in,
  input  logic               start_req,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               kind,
  output logic [3:0]         status,
  output logic [15:0]        num_chan,
  output logic [31:0]        rate_hz,
  output logic [15:0]        sample_bits,
  output logic [31:0]        data_len,
  output logic [15:0]        chan_index,
  output logic signed [31:0] pcm_value,
  output logic               last
);

  wavp_pkg::cmd_t     cmd;
  wavp_pkg::dp_stat_t dp_stat;

  wavp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dp_stat   (dp_stat),
    .cmd       (cmd)
  );

  wavp_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .byte_in     (byte_in),
    .start_req   (start_req),
    .cmd         (cmd),
    .dp_stat     (dp_stat),
    .kind        (kind),
    .status      (status),
    .num_chan    (num_chan),
    .rate_hz     (rate_hz),
    .sample_bits (sample_bits),
    .data_len    (data_len),
    .chan_index  (chan_index),
    .pcm_value   (pcm_value),
    .last        (last)
  );

  // no byte is taken while a result beat is pending
  a_hold_in: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

  // the final header byte yields a status beat after the check steps
  a_hdr_status: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && dp_stat.hdr_last) |->
      ##4 (out_valid && kind == wavp_pkg::KIND_STATUS))
    else $error("header status beat missing");

  // a sample beat carries an ok status
  a_smp_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == wavp_pkg::KIND_SAMPLE) |-> (status == wavp_pkg::STAT_OK))
    else $error("sample beat with nonzero status");

endmodule

[tb/sv/tb_wav_pcm_header_and_sample_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV header and sample parser testbench
// Streams whole and broken WAV files into the parser one byte per beat,
// predicts every status and sample beat in a cycle-free model of the parser,
// and compares the output beats in order, with random gaps and stalls on
// both sides and one long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_wav_pcm_header_and_sample_parser;

  localparam int          STUCK_LIMIT = 2000;
  localparam int          HOLD_CYCLES = 400;
  localparam int          TAIL_CYCLES = 20;
  localparam int          ITEM_TARGET = 800;
  localparam logic [127:0] TAG_TEXT   = "RIFFWAVEfmt data";
  localparam logic [31:0] RIFF_LE     = 32'h46464952;
  localparam logic [31:0] WAVE_LE     = 32'h45564157;
  localparam logic [31:0] FMT_LE      = 32'h20746D66;
  localparam logic [31:0] DATA_LE     = 32'h61746164;

  typedef struct packed {
    logic        kind;
    logic [3:0]  status;
    logic [15:0] num_chan;
    logic [31:0] rate_hz;
    logic [15:0] sample_bits;
    logic [31:0] data_len;
    logic [15:0] chan_index;
    logic [31:0] pcm_value;
    logic        last;
  } wav_beat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } file_byte_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         byte_in = 8'h00;
  logic               start_req = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               kind;
  logic [3:0]         status;
  logic [15:0]        num_chan;
  logic [31:0]        rate_hz;
  logic [15:0]        sample_bits;
  logic [31:0]        data_len;
  logic [15:0]        chan_index;
  logic signed [31:0] pcm_value;
  logic               last;

  wav_pcm_header_and_sample_parser DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .byte_in(byte_in), .start_req(start_req),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .status(status), .num_chan(num_chan), .rate_hz(rate_hz),
    .sample_bits(sample_bits), .data_len(data_len), .chan_index(chan_index),
    .pcm_value(pcm_value), .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  file_byte_t  file_bytes[$];
  wav_beat_t   pending_results[$];
  wav_beat_t   seen_results[$];
  file_byte_t  next_byte;
  wav_beat_t   got, want;
  int unsigned bytes_queued = 0;
  int unsigned bytes_taken = 0;
  int unsigned out_beats = 0;
  int unsigned status_beats = 0;
  int unsigned sample_beats = 0;
  int unsigned errors = 0;
  int unsigned cyc = 0;
  int unsigned stuck = 0;
  int unsigned hold_left = 0;
  bit          held = 1'b0;
  wire         quiet = (cyc >= 600) && (cyc < 1400);

  // parser model state
  logic [5:0]  hdr_pos;
  logic [3:0]  tag_ok;
  logic [63:0] fmt_w[3];
  logic [31:0] dsize;
  logic [31:0] dcnt;
  logic [31:0] acc;
  int unsigned bis;
  logic [15:0] chan_cnt;
  bit          frame_ok;

  task automatic clear_parser();
    hdr_pos  = '0;
    tag_ok   = 4'hF;
    fmt_w[0] = '0;
    fmt_w[1] = '0;
    fmt_w[2] = '0;
    dsize    = '0;
    dcnt     = '0;
    acc      = '0;
    bis      = 0;
    chan_cnt = '0;
    frame_ok = 1'b0;
  endtask

  function automatic logic [15:0] hdr_chan();
    return fmt_w[0][63:48];
  endfunction

  function automatic logic [15:0] hdr_bits();
    return fmt_w[2][31:16];
  endfunction

  function automatic logic [31:0] whole_bytes();
    logic [31:0] frame;
    frame = 32'(hdr_bits() >> 3) * 32'(hdr_chan());
    return (dsize / frame) * frame;
  endfunction

  function automatic wav_beat_t make_result(logic k);
    wav_beat_t r;
    r             = '0;
    r.kind        = k;
    r.num_chan    = hdr_chan();
    r.rate_hz     = fmt_w[1][31:0];
    r.sample_bits = hdr_bits();
    r.data_len    = dsize;
    return r;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic restart);
    wav_beat_t   r;
    int unsigned p;
    int unsigned tag_idx;
    int unsigned nb;
    logic [63:0] prod;
    logic [31:0] val;
    if (restart)
      clear_parser();
    nb = int'(hdr_bits() >> 3);
    if (hdr_pos < wavp_pkg::HDR_LEN) begin
      p = int'(hdr_pos);
      if (p < 4 || (p >= 8 && p < 16) || (p >= 36 && p < 40)) begin
        tag_idx = (p < 4) ? p : (p < 16) ? p - 4 : p - 24;
        if (b != TAG_TEXT[127 - 8 * tag_idx -: 8])
          tag_ok[tag_idx / 4] = 1'b0;
      end else if (p >= 16 && p < 36) begin
        fmt_w[((p - 16) >> 3) % 3][8 * ((p - 16) & 7) +: 8] = b;
      end else if (p >= 40) begin
        dsize[8 * (p - 40) +: 8] = b;
      end
      hdr_pos = hdr_pos + 6'd1;
      if (hdr_pos == wavp_pkg::HDR_LEN) begin
        nb = int'(hdr_bits() >> 3);
        frame_ok = (nb >= 1) && (nb <= 4) && (hdr_chan() >= 16'd1);
        r = make_result(wavp_pkg::KIND_STATUS);
        // later checks override earlier ones
        r.status = wavp_pkg::STAT_OK;
        if (!tag_ok[0]) r.status = wavp_pkg::STAT_RIFF;
        if (!tag_ok[1]) r.status = wavp_pkg::STAT_WAVE;
        if (!tag_ok[2]) r.status = wavp_pkg::STAT_FMT;
        if (fmt_w[0][31:0] != wavp_pkg::FMT_SIZE_PCM) r.status = wavp_pkg::STAT_FMT_SIZE;
        if (fmt_w[0][47:32] != wavp_pkg::FORMAT_PCM) r.status = wavp_pkg::STAT_NOT_PCM;
        if (!tag_ok[3]) r.status = wavp_pkg::STAT_DATA;
        prod = 64'(hdr_chan()) * 64'(fmt_w[1][31:0]) * 64'(hdr_bits());
        if ((prod >> 3) != 64'(fmt_w[1][63:32])) r.status = wavp_pkg::STAT_RATE;
        if (((32'(hdr_chan()) * 32'(hdr_bits())) >> 3) != 32'(fmt_w[2][15:0]))
          r.status = wavp_pkg::STAT_ALIGN;
        if (hdr_chan() > wavp_pkg::MAX_CHAN) r.status = wavp_pkg::STAT_CHAN;
        pending_results.push_back(r);
      end
    end else if (frame_ok && dcnt < whole_bytes()) begin
      acc[8 * bis +: 8] = b;
      dcnt = dcnt + 32'd1;
      if (bis + 1 < nb) begin
        bis++;
      end else begin
        val = acc;
        if (nb < 4 && val[8 * nb - 1])
          val = val | ~((32'd1 << (8 * nb)) - 32'd1);
        r = make_result(wavp_pkg::KIND_SAMPLE);
        r.chan_index = chan_cnt;
        r.pcm_value  = val;
        r.last       = (dcnt == whole_bytes());
        pending_results.push_back(r);
        acc = '0;
        bis = 0;
        chan_cnt = chan_cnt + 16'd1;
        if (chan_cnt >= hdr_chan())
          chan_cnt = '0;
      end
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input logic s);
    file_bytes.push_back('{data: b, start: s});
    bytes_queued++;
  endtask

  // Build one file: header (cut short if hdr_cut < 44), then n_data random bytes.
  task automatic add_file(input logic with_start, input logic [3:0] bad_tags,
                          input logic [31:0] fmt_size, input logic [15:0] fmt,
                          input logic [15:0] chan, input logic [31:0] rate,
                          input logic [31:0] brate, input logic [15:0] align,
                          input logic [15:0] bits, input logic [31:0] dlen,
                          input int hdr_cut, input int n_data);
    logic [351:0] hdr;
    int           base;
    hdr = {dlen, DATA_LE, bits, align, brate, rate, chan, fmt, fmt_size,
           FMT_LE, WAVE_LE, 32'($urandom), RIFF_LE};
    for (int t = 0; t < 4; t++) begin
      if (bad_tags[t]) begin
        base = (t == 0) ? 0 : (t == 1) ? 8 : (t == 2) ? 12 : 36;
        base = base + int'($urandom_range(0, 3));
        hdr[8 * base +: 8] = hdr[8 * base +: 8] ^ 8'($urandom_range(1, 255));
      end
    end
    for (int i = 0; i < hdr_cut; i++)
      push_byte(hdr[8 * i +: 8], with_start && (i == 0));
    for (int i = 0; i < n_data; i++)
      push_byte(8'($urandom), 1'b0);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // driver: offer the next byte once the current beat is taken or the line is idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        parse_byte(byte_in, start_req);
        bytes_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (file_bytes.size() > 0 && (quiet || $urandom_range(99) >= 26)) begin
          next_byte = file_bytes.pop_front();
          in_valid  <= 1'b1;
          byte_in   <= next_byte.data;
          start_req <= next_byte.start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: capture output beats, stall at random, hold off once for a long stretch
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        seen_results.push_back({kind, status, num_chan, rate_hz, sample_bits, data_len,
                                chan_index, pcm_value, last});
        out_beats++;
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (!held && out_beats == 30) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      out_stall <= (hold_left > 0) || (!quiet && $urandom_range(99) < 26);
    end
  end

  // compare away from the clock edge so both queues are settled
  always @(negedge clk) begin
    while (seen_results.size() > 0) begin
      got = seen_results.pop_front();
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: beat with nothing expected, expected none actual kind %0d status %0d pcm %0h",
                 $time, got.kind, got.status, got.pcm_value);
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(got.kind));
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("num_chan", 32'(want.num_chan), 32'(got.num_chan));
        check_field("rate_hz", want.rate_hz, got.rate_hz);
        check_field("sample_bits", 32'(want.sample_bits), 32'(got.sample_bits));
        check_field("data_len", want.data_len, got.data_len);
        check_field("chan_index", 32'(want.chan_index), 32'(got.chan_index));
        check_field("pcm_value", want.pcm_value, got.pcm_value);
        check_field("last", 32'(want.last), 32'(got.last));
        if (want.kind == wavp_pkg::KIND_STATUS)
          status_beats++;
        else
          sample_beats++;
      end
    end
  end

  // watchdog: count cycles with no beat on either side
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      stuck <= 0;
    else
      stuck <= stuck + 1;
    if (stuck >= STUCK_LIMIT) begin
      $display("tb: no beat for %0d cycles, %0d results outstanding", stuck,
               pending_results.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int unsigned directed_bytes;
    logic [15:0] r_chan, r_bits, r_align;
    logic [31:0] r_rate, r_brate, r_dsize;
    int          frame, n_data;

    clear_parser();

    // no start flag on the very first file; trailing bytes past the whole frames
    add_file(1'b0, 4'h0, 32'd16, 16'd1, 16'd2, 32'd8000, 32'd32000, 16'd4, 16'd16,
             32'd10, 44, 12);
    // 8-bit mono with the byte extremes, data tag broken
    add_file(1'b1, 4'h8, 32'd16, 16'd1, 16'd1, 32'd44100, 32'd44100, 16'd1, 16'd8,
             32'd4, 44, 0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hFF, 1'b0);
    // 32-bit mono with RIFF broken, 24-bit stereo with a partial frame and WAVE broken
    add_file(1'b1, 4'h1, 32'd16, 16'd1, 16'd1, 32'd48000, 32'd192000, 16'd4, 16'd32,
             32'd8, 44, 8);
    add_file(1'b1, 4'h2, 32'd16, 16'd1, 16'd2, 32'd48000, 32'd288000, 16'd6, 16'd24,
             32'd13, 44, 14);
    // fmt tag broken
    add_file(1'b1, 4'h4, 32'd16, 16'd1, 16'd1, 32'd8000, 32'd8000, 16'd1, 16'd8,
             32'd2, 44, 2);
    // fmt size with under 8 bits, format with over 32 bits, byte rate with no channels
    add_file(1'b1, 4'h0, 32'd17, 16'd1, 16'd1, 32'd8000, 32'd4000, 16'd0, 16'd4,
             32'd8, 44, 4);
    add_file(1'b1, 4'h0, 32'd16, 16'd3, 16'd1, 32'd8000, 32'd40000, 16'd5, 16'd40,
             32'd10, 44, 5);
    add_file(1'b1, 4'h0, 32'd16, 16'd1, 16'd0, 32'd8000, 32'd1, 16'd0, 16'd16,
             32'd8, 44, 4);
    // block align with 12-bit taken as one byte, too many channels (still decoded)
    add_file(1'b1, 4'h0, 32'd16, 16'd1, 16'd1, 32'd8000, 32'd12000, 16'd2, 16'd12,
             32'd3, 44, 3);
    add_file(1'b1, 4'h0, 32'd16, 16'd1, 16'd3, 32'd8000, 32'd48000, 16'd6, 16'd16,
             32'd12, 44, 14);
    // restart inside a header, then inside a sample
    add_file(1'b1, 4'h0, 32'd16, 16'd1, 16'd2, 32'd8000, 32'd32000, 16'd4, 16'd16,
             32'd100, 20, 0);
    add_file(1'b1, 4'h0, 32'd16, 16'd1, 16'd2, 32'd8000, 32'd32000, 16'd4, 16'd16,
             32'd100, 44, 5);
    // field extremes: byte-rate product past 32 bits, all-ones header, empty data
    add_file(1'b1, 4'h0, 32'd16, 16'd1, 16'd2, 32'hFFFF_FFFF, 32'hFFFF_FFF8, 16'd8,
             16'd32, 32'hFFFF_FFFF, 44, 8);
    add_file(1'b1, 4'h0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 44, 2);
    add_file(1'b1, 4'h0, 32'd0, 16'd0, 16'd1, 32'd0, 32'd0, 16'd1, 16'd8, 32'd0, 44, 4);
    directed_bytes = bytes_queued;

    // mostly well-formed files with random content, some broken or cut short
    while (bytes_queued < ITEM_TARGET) begin
      r_chan = 16'($urandom_range(1, 2));
      r_bits = 16'(8 * $urandom_range(1, 4));
      r_rate = 32'($urandom_range(8000, 96000));
      if ($urandom_range(99) < 10) r_chan = 16'($urandom_range(0, 5));
      if ($urandom_range(99) < 10) r_bits = 16'($urandom_range(0, 48));
      if ($urandom_range(99) < 10) r_rate = $urandom;
      r_brate = 32'((64'(r_chan) * 64'(r_rate) * 64'(r_bits)) >> 3);
      r_align = 16'((32'(r_chan) * 32'(r_bits)) >> 3);
      if ($urandom_range(99) < 8) r_brate = r_brate ^ (32'd1 << $urandom_range(0, 31));
      if ($urandom_range(99) < 5) r_align = r_align + 16'd1;
      frame = int'(r_bits / 16'd8) * int'(r_chan);
      if (frame == 0) frame = 1;
      r_dsize = 32'($urandom_range(0, 5) * frame + $urandom_range(0, frame - 1));
      if ($urandom_range(99) < 5) r_dsize = $urandom;
      n_data = (r_dsize > 48) ? 48 : int'(r_dsize);
      n_data = n_data + int'($urandom_range(0, 4));
      if ($urandom_range(99) < 10) n_data = int'($urandom_range(0, n_data));
      add_file($urandom_range(99) < 95,
               ($urandom_range(99) < 8) ? 4'($urandom) : 4'h0,
               ($urandom_range(99) < 5) ? $urandom : 32'd16,
               ($urandom_range(99) < 5) ? 16'($urandom) : 16'd1,
               r_chan, r_rate, r_brate, r_align, r_bits, r_dsize,
               ($urandom_range(99) < 5) ? int'($urandom_range(1, 43)) : 44, n_data);
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (bytes_taken < bytes_queued)
      @(posedge clk);
    while (pending_results.size() != 0 || seen_results.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    #1;
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0t: %0d results expected but never seen", $time, pending_results.size());
    end

    $display("tb: %0d file bytes taken (%0d directed), %0d header and %0d sample beats compared",
             bytes_taken, directed_bytes, status_beats, sample_beats);
    $display("tb: %0d mismatches", errors);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
